>>> hdl/vgmcd_pkg.sv
// shared constants, types and the command length table of the command decoder
package vgmcd_pkg;

    localparam int OFFSET_WIDTH    = 32;
    localparam int DL_WIDTH        = 32;
    localparam int RATE_WIDTH      = 18;
    localparam int WAIT_WIDTH      = 16;
    localparam int DELAY_WIDTH     = 19;
    localparam int ADDR_WIDTH      = 9;
    localparam int VALUE_WIDTH     = 8;
    localparam int BYTE_WIDTH      = 8;
    localparam int ARGS_WIDTH      = 3;
    localparam int TDATA_WIDTH     = 40;
    localparam int TPAD_WIDTH      = TDATA_WIDTH - ADDR_WIDTH - VALUE_WIDTH - DELAY_WIDTH;
    localparam int CFG_INDEX_WIDTH = 1;
    localparam int CFG_DATA_WIDTH  = 32;

    // configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OUTPUT_RATE = 1'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DATA_LENGTH = 1'd1;

    localparam logic [RATE_WIDTH-1:0] OUTPUT_RATE_RESET = 18'd49716;
    localparam logic [DL_WIDTH-1:0]   DATA_LENGTH_RESET = 32'd1;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_WRITE = 2'd0;
    localparam kind_t KIND_DELAY = 2'd1;
    localparam kind_t KIND_END   = 2'd2;

    // opcodes
    localparam logic [7:0] OP_WRITE_FIRST = 8'h5A;
    localparam logic [7:0] OP_WRITE_HIGH  = 8'h5F;
    localparam logic [7:0] OP_WAIT_N      = 8'h61;
    localparam logic [7:0] OP_WAIT_NTSC   = 8'h62;
    localparam logic [7:0] OP_WAIT_PAL    = 8'h63;
    localparam logic [7:0] OP_END         = 8'h66;
    localparam logic [7:0] OP_WAIT_SHORT  = 8'h70;
    localparam logic [7:0] OP_WAIT_NIBBLE = 8'h80;

    localparam logic [WAIT_WIDTH-1:0] WAIT_NTSC_SAMPLES = 16'd735;
    localparam logic [WAIT_WIDTH-1:0] WAIT_PAL_SAMPLES  = 16'd882;

    // divide by 44100 as a shift by 2 then a reciprocal multiply by 1/11025
    localparam int SAMPLE_RATE = 44100;
    localparam int PRE_SHIFT   = 2;
    localparam int DIV_ODD     = SAMPLE_RATE / 4;
    localparam int PROD_WIDTH  = WAIT_WIDTH + RATE_WIDTH;
    localparam int X_WIDTH     = PROD_WIDTH - PRE_SHIFT;
    localparam int RECIP_SHIFT = 45;
    localparam logic [63:0] RECIP_WIDE = (64'd1 << RECIP_SHIFT) / 64'(DIV_ODD);
    localparam logic [X_WIDTH-1:0] RECIP = RECIP_WIDE[X_WIDTH-1:0];

    // argument bytes that follow an opcode (command length minus one)
    function automatic logic [ARGS_WIDTH-1:0] cmd_args(input logic [7:0] op);
        logic [ARGS_WIDTH-1:0] n;
        n = 3'd0;
        priority if (op >= 8'h5A && op <= 8'h5F) n = 3'd2;
        else if (op == 8'h61)                    n = 3'd2;
        else if (op >= 8'h62 && op <= 8'h8F)     n = 3'd0;
        else if (op >= 8'h30 && op <= 8'h3F)     n = 3'd1;
        else if (op >= 8'h40 && op <= 8'h4E)     n = 3'd2;
        else if (op >= 8'h4F && op <= 8'h50)     n = 3'd1;
        else if (op >= 8'h51 && op <= 8'h61)     n = 3'd2;
        else if (op >= 8'hA0 && op <= 8'hBF)     n = 3'd2;
        else if (op >= 8'hC0 && op <= 8'hDF)     n = 3'd3;
        else if (op >= 8'hE0)                    n = 3'd4;
        else                                     n = 3'd0;
        return n;
    endfunction

endpackage

>>> hdl/vgm_command_decoder.sv
// command stream decoder: byte collection, command decode and wait scaling pipeline
//
//  channel   | direction | transaction contents
//  ----------+-----------+-----------------------------------------------------
//  s_axis    | in        | tdata[7:0] stream_byte
//  m_axis    | out       | tdata addr/value/delay, tuser kind, tlast stream_end
//  cfg       | in        | cfg_index register, cfg_data value (always ready)
//
// one stream byte is taken every cycle unless the pipeline stalls; a result passes
// the decode register and the two multiplier stages plus the correction stage of
// the rate scaling on its way to m_axis.
// each full stage holds while the next one is full and cannot move on, so bubbles
// from bytes without a result are squeezed out under output stall.
// rst_n clears the command state and all stage valid flags and resets the configuration.
module vgm_command_decoder
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [vgmcd_pkg::BYTE_WIDTH-1:0]       s_axis_tdata,   // [7:0] stream_byte
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // [8:0] reg_address, [16:9] reg_value, [35:17] delay_ticks, [39:36] zero
    output logic [vgmcd_pkg::TDATA_WIDTH-1:0]      m_axis_tdata,
    output vgmcd_pkg::kind_t                       m_axis_tuser,   // [1:0] kind
    output logic                                   m_axis_tlast,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [vgmcd_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [vgmcd_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);
    import vgmcd_pkg::*;

    // configuration
    logic [RATE_WIDTH-1:0]   output_rate_reg;
    logic [DL_WIDTH-1:0]     data_length_reg;

    // command state
    logic [7:0]              opcode_reg, opcode_next;
    logic [ARGS_WIDTH-1:0]   bytes_left_reg, bytes_left_next;
    logic [7:0]              arg_low_reg, arg_low_next;
    logic [7:0]              arg_high_reg, arg_high_next;
    logic [OFFSET_WIDTH-1:0] byte_offset_reg, byte_offset_next;
    logic                    ended_reg, ended_next;

    logic                    in_fire;
    logic [OFFSET_WIDTH-1:0] offset_adv;
    logic [ARGS_WIDTH-1:0]   arg_pos;
    logic                    at_end;
    logic                    end_flag;
    logic                    finish;
    logic [WAIT_WIDTH-1:0]   fin_wait;

    // decode result
    logic                    res_valid;
    kind_t                   res_kind;
    logic [ADDR_WIDTH-1:0]   res_addr;
    logic [VALUE_WIDTH-1:0]  res_value;
    logic [WAIT_WIDTH-1:0]   res_wait;
    logic                    res_end;

    // stage 1: decoded command
    logic                    s1_valid_reg;
    kind_t                   s1_kind_reg;
    logic [ADDR_WIDTH-1:0]   s1_addr_reg;
    logic [VALUE_WIDTH-1:0]  s1_value_reg;
    logic [WAIT_WIDTH-1:0]   s1_wait_reg;
    logic                    s1_end_reg;

    // stage 2: wait times rate, pre-shifted
    logic                    s2_valid_reg;
    kind_t                   s2_kind_reg;
    logic [ADDR_WIDTH-1:0]   s2_addr_reg;
    logic [VALUE_WIDTH-1:0]  s2_value_reg;
    logic [X_WIDTH-1:0]      s2_x_reg;
    logic                    s2_end_reg;
    logic [PROD_WIDTH-1:0]   rate_prod;

    // stage 3: quotient estimate, low by at most one
    logic                    s3_valid_reg;
    kind_t                   s3_kind_reg;
    logic [ADDR_WIDTH-1:0]   s3_addr_reg;
    logic [VALUE_WIDTH-1:0]  s3_value_reg;
    logic [X_WIDTH-1:0]      s3_x_reg;
    logic [DELAY_WIDTH-1:0]  s3_q0_reg;
    logic                    s3_end_reg;
    logic [63:0]             recip_prod;

    // output register
    logic                    out_valid_reg;
    logic [TDATA_WIDTH-1:0]  out_data_reg;
    kind_t                   out_kind_reg;
    logic                    out_last_reg;
    logic [X_WIDTH-1:0]      q0_times;
    logic [X_WIDTH-1:0]      remainder;
    logic [DELAY_WIDTH-1:0]  delay_q;

    logic                    out_ready;
    logic                    s3_ready;
    logic                    s2_ready;
    logic                    s1_ready;

    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign s3_ready      = !s3_valid_reg || out_ready;
    assign s2_ready      = !s2_valid_reg || s3_ready;
    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign s_axis_tready = s1_ready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    // saturating byte count
    assign offset_adv = (byte_offset_reg == {OFFSET_WIDTH{1'b1}}) ? byte_offset_reg
                                                                  : byte_offset_reg + 1'b1;
    assign arg_pos    = cmd_args(opcode_reg) - bytes_left_reg;
    assign at_end     = DL_WIDTH'(offset_adv) >= data_length_reg;
    assign end_flag   = (opcode_next == OP_END) || at_end;

    always_comb
    begin
        priority if (opcode_next == OP_WAIT_N)
            fin_wait = {arg_high_next, arg_low_next};
        else if (opcode_next == OP_WAIT_NTSC)
            fin_wait = WAIT_NTSC_SAMPLES;
        else if (opcode_next == OP_WAIT_PAL)
            fin_wait = WAIT_PAL_SAMPLES;
        else if (opcode_next[7:4] == OP_WAIT_SHORT[7:4])
            fin_wait = WAIT_WIDTH'(opcode_next[3:0]) + WAIT_WIDTH'(1);
        else if (opcode_next[7:4] == OP_WAIT_NIBBLE[7:4])
            fin_wait = WAIT_WIDTH'(opcode_next[3:0]);
        else
            fin_wait = '0;
    end

    always_comb
    begin
        opcode_next      = opcode_reg;
        bytes_left_next  = bytes_left_reg;
        arg_low_next     = arg_low_reg;
        arg_high_next    = arg_high_reg;
        byte_offset_next = byte_offset_reg;
        ended_next       = ended_reg;
        finish           = 1'b0;
        res_valid        = 1'b0;
        res_kind         = KIND_WRITE;
        res_addr         = '0;
        res_value        = '0;
        res_wait         = '0;
        res_end          = 1'b0;
        if (in_fire && !ended_reg)
        begin
            if (bytes_left_reg == '0)
            begin
                if (DL_WIDTH'(byte_offset_reg) >= data_length_reg)
                begin
                    // opcode arriving with the length already used up
                    ended_next = 1'b1;
                    res_valid  = 1'b1;
                    res_kind   = KIND_END;
                    res_end    = 1'b1;
                end
                else
                begin
                    opcode_next      = s_axis_tdata;
                    arg_low_next     = '0;
                    arg_high_next    = '0;
                    bytes_left_next  = cmd_args(s_axis_tdata);
                    byte_offset_next = offset_adv;
                    finish           = (cmd_args(s_axis_tdata) == '0);
                end
            end
            else
            begin
                if (arg_pos == 3'd0)
                    arg_low_next = s_axis_tdata;
                else if (arg_pos == 3'd1)
                    arg_high_next = s_axis_tdata;
                byte_offset_next = offset_adv;
                bytes_left_next  = bytes_left_reg - 1'b1;
                finish           = (bytes_left_reg == 3'd1);
            end
            if (finish)
            begin
                ended_next = end_flag;
                if (opcode_next >= OP_WRITE_FIRST && opcode_next <= OP_WRITE_HIGH)
                begin
                    res_valid = 1'b1;
                    res_kind  = KIND_WRITE;
                    res_addr  = {opcode_next == OP_WRITE_HIGH, arg_low_next};
                    res_value = arg_high_next;
                    res_end   = at_end;
                end
                else if (fin_wait != '0)
                begin
                    res_valid = 1'b1;
                    res_kind  = KIND_DELAY;
                    res_wait  = fin_wait;
                    res_end   = end_flag;
                end
                else if (end_flag)
                begin
                    res_valid = 1'b1;
                    res_kind  = KIND_END;
                    res_end   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            output_rate_reg <= OUTPUT_RATE_RESET;
            data_length_reg <= DATA_LENGTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_OUTPUT_RATE: output_rate_reg <= cfg_data[RATE_WIDTH-1:0];
                REG_DATA_LENGTH: data_length_reg <= cfg_data[DL_WIDTH-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opcode_reg      <= '0;
            bytes_left_reg  <= '0;
            arg_low_reg     <= '0;
            arg_high_reg    <= '0;
            byte_offset_reg <= '0;
            ended_reg       <= 1'b0;
        end
        else
        begin
            opcode_reg      <= opcode_next;
            bytes_left_reg  <= bytes_left_next;
            arg_low_reg     <= arg_low_next;
            arg_high_reg    <= arg_high_next;
            byte_offset_reg <= byte_offset_next;
            ended_reg       <= ended_next;
        end
    end

    assign rate_prod  = PROD_WIDTH'(s1_wait_reg) * PROD_WIDTH'(output_rate_reg);
    assign recip_prod = 64'(s2_x_reg) * 64'(RECIP);
    assign q0_times   = X_WIDTH'(s3_q0_reg) * X_WIDTH'(DIV_ODD);
    assign remainder  = s3_x_reg - q0_times;
    assign delay_q    = (remainder >= X_WIDTH'(DIV_ODD)) ? s3_q0_reg + 1'b1 : s3_q0_reg;

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_fire && res_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
            if (out_ready)
                out_valid_reg <= s3_valid_reg;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_kind_reg  <= res_kind;
            s1_addr_reg  <= res_addr;
            s1_value_reg <= res_value;
            s1_wait_reg  <= res_wait;
            s1_end_reg   <= res_end;
        end
        if (s2_ready)
        begin
            s2_kind_reg  <= s1_kind_reg;
            s2_addr_reg  <= s1_addr_reg;
            s2_value_reg <= s1_value_reg;
            s2_x_reg     <= rate_prod[PROD_WIDTH-1:PRE_SHIFT];
            s2_end_reg   <= s1_end_reg;
        end
        if (s3_ready)
        begin
            s3_kind_reg  <= s2_kind_reg;
            s3_addr_reg  <= s2_addr_reg;
            s3_value_reg <= s2_value_reg;
            s3_x_reg     <= s2_x_reg;
            s3_q0_reg    <= recip_prod[RECIP_SHIFT+DELAY_WIDTH-1:RECIP_SHIFT];
            s3_end_reg   <= s2_end_reg;
        end
        if (out_ready)
        begin
            out_data_reg <= {{TPAD_WIDTH{1'b0}}, delay_q, s3_value_reg, s3_addr_reg};
            out_kind_reg <= s3_kind_reg;
            out_last_reg <= s3_end_reg;
        end
    end

`ifndef SYNTHESIS
    a_ended_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ended_reg |=> ended_reg)
        else $error("end of stream flag cleared");

    a_silent_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (ended_reg && s1_ready) |=> !s1_valid_reg)
        else $error("result produced after end of stream");

    a_end_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_END) |-> m_axis_tlast)
        else $error("end result without stream_end");

    a_reg_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != KIND_WRITE) |-> m_axis_tdata[16:0] == '0)
        else $error("register fields set on a non-write result");

    a_args_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        bytes_left_reg <= 3'd4)
        else $error("argument count beyond longest command");
`endif

endmodule

>>> tb/vgm_command_decoder_tb.sv
// self-checking testbench of the command stream decoder with its own decode predictor
module vgm_command_decoder_tb;

    import vgmcd_pkg::*;

    localparam logic [7:0] OP_WAIT_SHORT_LAST  = 8'h7F;
    localparam logic [7:0] OP_WAIT_NIBBLE_LAST = 8'h8F;
    localparam logic [7:0] OP_SKIP_TWO         = 8'h30;
    localparam logic [7:0] OP_SKIP_FOUR        = 8'hC0;
    localparam logic [7:0] OP_SKIP_FIVE        = 8'hE0;
    localparam logic [7:0] OP_UNKNOWN          = 8'h00;
    localparam logic [RATE_WIDTH-1:0] RATE_MAX = '1;
    localparam int IDLE_LIMIT  = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_BYTES = 80;

    typedef enum int {END_BY_OPCODE, END_BY_LENGTH, END_AFTER_LENGTH, END_STRADDLING} ending_t;

    typedef struct packed {
        kind_t                   kind;
        logic [ADDR_WIDTH-1:0]   address;
        logic [VALUE_WIDTH-1:0]  value;
        logic [DELAY_WIDTH-1:0]  ticks;
        logic [TPAD_WIDTH-1:0]   pad;
        logic                    last;
    } stream_event_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [BYTE_WIDTH-1:0]       s_axis_tdata = '0;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [TDATA_WIDTH-1:0]      m_axis_tdata;
    kind_t                       m_axis_tuser;
    logic                        m_axis_tlast;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0]  cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]   cfg_data = '0;

    // predictor copy of the decoder state and configuration
    logic [RATE_WIDTH-1:0]   rate_setting = OUTPUT_RATE_RESET;
    logic [DL_WIDTH-1:0]     length_setting = DATA_LENGTH_RESET;
    logic [7:0]              cur_op = '0;
    logic [ARGS_WIDTH-1:0]   args_owed = '0;
    logic [7:0]              arg_lo = '0;
    logic [7:0]              arg_hi = '0;
    logic [OFFSET_WIDTH-1:0] bytes_taken = '0;
    bit                      stream_done = 1'b0;

    logic [7:0]    bytes_to_send[$];
    stream_event_t events_due[$];
    int            mismatch_count = 0;
    int            send_gap = 0;
    int            recv_stall = 0;
    int            hold_left = 0;
    int            hold_requests = 0;
    int            holds_served = 0;
    int            idle_cycles = 0;
    bit            send_calm = 1'b0;
    bit            recv_calm = 1'b0;

    vgm_command_decoder dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #4 clk = ~clk;

    // bytes in a command, opcode included
    function automatic int command_length(input logic [7:0] op);
        if (op >= OP_WRITE_FIRST && op <= OP_WRITE_HIGH) return 3;
        if (op == OP_WAIT_N) return 3;
        if (op >= OP_WAIT_NTSC && op <= OP_WAIT_NIBBLE_LAST) return 1;
        if (op >= 8'h30 && op <= 8'h3F) return 2;
        if (op >= 8'h40 && op <= 8'h4E) return 3;
        if (op >= 8'h4F && op <= 8'h50) return 2;
        if (op >= 8'h51 && op <= 8'h61) return 3;
        if (op >= 8'hA0 && op <= 8'hBF) return 3;
        if (op >= 8'hC0 && op <= 8'hDF) return 4;
        if (op >= 8'hE0) return 5;
        return 1;
    endfunction

    task automatic push_event(input kind_t kind, input logic [ADDR_WIDTH-1:0] address,
                              input logic [VALUE_WIDTH-1:0] value,
                              input logic [DELAY_WIDTH-1:0] ticks, input logic last);
        stream_event_t ev;
        ev.kind    = kind;
        ev.address = address;
        ev.value   = value;
        ev.ticks   = ticks;
        ev.pad     = '0;
        ev.last    = last;
        events_due.push_back(ev);
    endtask

    task automatic finish_command();
        logic [WAIT_WIDTH-1:0] samples;
        logic [63:0]           product;
        bit                    at_end;
        samples = '0;
        at_end  = bytes_taken >= length_setting;
        if (cur_op == OP_END || at_end)
            stream_done = 1'b1;
        if (cur_op >= OP_WRITE_FIRST && cur_op <= OP_WRITE_HIGH)
        begin
            push_event(KIND_WRITE, {cur_op == OP_WRITE_HIGH, arg_lo}, arg_hi, '0, at_end);
            return;
        end
        if (cur_op == OP_WAIT_N)
            samples = {arg_hi, arg_lo};
        else if (cur_op == OP_WAIT_NTSC)
            samples = WAIT_NTSC_SAMPLES;
        else if (cur_op == OP_WAIT_PAL)
            samples = WAIT_PAL_SAMPLES;
        else if (cur_op >= OP_WAIT_SHORT && cur_op <= OP_WAIT_SHORT_LAST)
            samples = WAIT_WIDTH'(cur_op - OP_WAIT_SHORT) + WAIT_WIDTH'(1);
        else if (cur_op >= OP_WAIT_NIBBLE && cur_op <= OP_WAIT_NIBBLE_LAST)
            samples = WAIT_WIDTH'(cur_op - OP_WAIT_NIBBLE);
        if (samples != 0)
        begin
            product = (64'(samples) * 64'(rate_setting)) / 64'(SAMPLE_RATE);
            push_event(KIND_DELAY, '0, '0, product[DELAY_WIDTH-1:0], stream_done);
        end
        else if (stream_done)
            push_event(KIND_END, '0, '0, '0, 1'b1);
    endtask

    task automatic decode_byte(input logic [7:0] b);
        int pos;
        if (stream_done)
            return;
        if (args_owed == 0)
        begin
            // an opcode arriving once the length is used up ends the stream by itself
            if (bytes_taken >= length_setting)
            begin
                stream_done = 1'b1;
                push_event(KIND_END, '0, '0, '0, 1'b1);
                return;
            end
            cur_op    = b;
            arg_lo    = '0;
            arg_hi    = '0;
            args_owed = ARGS_WIDTH'(command_length(b) - 1);
        end
        else
        begin
            pos = command_length(cur_op) - 1 - args_owed;
            if (pos == 0)
                arg_lo = b;
            else if (pos == 1)
                arg_hi = b;
            args_owed = args_owed - 1'b1;
        end
        if (bytes_taken != '1)
            bytes_taken = bytes_taken + 1'b1;
        if (args_owed == 0)
            finish_command();
    endtask

    function automatic logic [7:0] random_opcode(input bit allow_end);
        int         r;
        logic [7:0] op;
        r = $urandom_range(0, 99);
        if (r < 35)
            op = 8'($urandom_range(OP_WRITE_FIRST, OP_WRITE_HIGH));
        else if (r < 45)
            op = OP_WAIT_N;
        else if (r < 50)
            op = ($urandom_range(0, 1) == 0) ? OP_WAIT_NTSC : OP_WAIT_PAL;
        else if (r < 60)
            op = 8'($urandom_range(OP_WAIT_SHORT, OP_WAIT_NIBBLE_LAST));
        else
            op = 8'($urandom_range(0, 255));
        while (!allow_end && op == OP_END)
            op = 8'($urandom_range(0, 255));
        return op;
    endfunction

    task automatic queue_command(input logic [7:0] op);
        bit zero_args;
        zero_args = (op == OP_WAIT_N) && ($urandom_range(0, 5) == 0);
        bytes_to_send.push_back(op);
        repeat (command_length(op) - 1)
            bytes_to_send.push_back(zero_args ? 8'h00 : 8'($urandom_range(0, 255)));
    endtask

    task automatic write_register(input logic [CFG_INDEX_WIDTH-1:0] index,
                                  input logic [CFG_DATA_WIDTH-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (index == REG_OUTPUT_RATE)
            rate_setting = value[RATE_WIDTH-1:0];
        else
            length_setting = value;
        @(posedge clk);
    endtask

    // all bytes sent and all results in, then room for commands with no result
    task automatic wait_idle();
        while (bytes_to_send.size() != 0 || s_axis_tvalid || events_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // sender
    always @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            decode_byte(s_axis_tdata);
        if (!s_axis_tvalid || s_axis_tready)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (bytes_to_send.size() != 0)
            begin
                s_axis_tdata  <= bytes_to_send.pop_front();
                s_axis_tvalid <= 1'b1;
                send_gap = send_calm ? 0 : $urandom_range(0, 17);
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk)
    begin
        stream_event_t seen;
        stream_event_t due;
        if (m_axis_tvalid && m_axis_tready)
        begin
            seen.kind    = m_axis_tuser;
            seen.address = m_axis_tdata[ADDR_WIDTH-1:0];
            seen.value   = m_axis_tdata[ADDR_WIDTH +: VALUE_WIDTH];
            seen.ticks   = m_axis_tdata[ADDR_WIDTH+VALUE_WIDTH +: DELAY_WIDTH];
            seen.pad     = m_axis_tdata[TDATA_WIDTH-1 -: TPAD_WIDTH];
            seen.last    = m_axis_tlast;
            if (events_due.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: expected no transaction,", $time,
                         " got kind %0d addr %h value %h ticks %0d last %b",
                         seen.kind, seen.address, seen.value, seen.ticks, seen.last);
            end
            else
            begin
                due = events_due.pop_front();
                if (seen !== due)
                begin
                    mismatch_count++;
                    $display("%0t: expected kind %0d addr %h value %h ticks %0d pad %h last %b,",
                             $time, due.kind, due.address, due.value, due.ticks, due.pad,
                             due.last,
                             " got kind %0d addr %h value %h ticks %0d pad %h last %b",
                             seen.kind, seen.address, seen.value, seen.ticks,
                             seen.pad, seen.last);
                end
            end
            recv_stall = recv_calm ? 0 : $urandom_range(0, 17);
        end
        if (hold_requests != holds_served)
        begin
            holds_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (recv_stall > 0)
        begin
            recv_stall--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("vgm_command_decoder: mismatch");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] opening [0:24];
        ending_t    ending;
        int         phase;
        int         first;
        opening = '{OP_WRITE_FIRST, 8'h00, 8'h00, OP_WRITE_HIGH, 8'hFF, 8'hFF,
                    OP_WAIT_N, 8'hFF, 8'hFF, OP_WAIT_N, 8'h00, 8'h00,
                    OP_WAIT_NTSC, OP_WAIT_PAL, OP_WAIT_SHORT, OP_WAIT_SHORT_LAST,
                    OP_WAIT_NIBBLE, OP_WAIT_NIBBLE_LAST, OP_SKIP_TWO, 8'hA5, OP_UNKNOWN,
                    OP_SKIP_FOUR, 8'h5A, 8'hC3, 8'h3C};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening at the reset rate, length pushed out of reach
        write_register(REG_DATA_LENGTH, '1);
        foreach (opening[i])
            bytes_to_send.push_back(opening[i]);

        for (phase = 0; phase < 8; phase++)
        begin
            wait_idle();
            case (phase)
                0:       write_register(REG_OUTPUT_RATE, '0);
                1:       write_register(REG_OUTPUT_RATE, 1);
                2:       write_register(REG_OUTPUT_RATE, SAMPLE_RATE);
                3:       write_register(REG_OUTPUT_RATE, CFG_DATA_WIDTH'(RATE_MAX));
                default: write_register(REG_OUTPUT_RATE, $urandom_range(1, RATE_MAX));
            endcase
            if (phase % 2 == 1)
                write_register(REG_DATA_LENGTH, '1);
            else
                write_register(REG_DATA_LENGTH, bytes_taken + $urandom_range(1000, 1000000));
            send_calm = ($urandom_range(0, 2) == 0);
            recv_calm = ($urandom_range(0, 2) == 0);
            if (phase == 3)
            begin
                // receiver holds off while bytes keep coming, backing the pipe up
                send_calm = 1'b1;
                recv_calm = 1'b0;
                hold_requests++;
            end
            first = bytes_to_send.size();
            while (bytes_to_send.size() - first < PHASE_BYTES)
                queue_command(random_opcode(1'b0));
        end

        wait_idle();
        write_register(REG_OUTPUT_RATE, $urandom_range(1, RATE_MAX));
        send_calm = ($urandom_range(0, 1) == 0);
        recv_calm = ($urandom_range(0, 1) == 0);
        ending = ending_t'($urandom_range(0, 3));
        case (ending)
            END_BY_OPCODE:
            begin
                write_register(REG_DATA_LENGTH, '1);
                repeat ($urandom_range(0, 6))
                    queue_command(random_opcode(1'b0));
                queue_command(OP_END);
            end
            END_BY_LENGTH:
            begin
                write_register(REG_DATA_LENGTH, bytes_taken + $urandom_range(1, 15));
                repeat (20)
                    queue_command(random_opcode(1'b1));
            end
            END_AFTER_LENGTH:
            begin
                write_register(REG_DATA_LENGTH, $urandom_range(0, 1));
                repeat (3)
                    queue_command(random_opcode(1'b1));
            end
            default:
            begin
                // command starting just below the length runs on past it
                write_register(REG_DATA_LENGTH, bytes_taken + 1);
                if ($urandom_range(0, 1) == 0)
                    queue_command(8'($urandom_range(OP_WRITE_FIRST, OP_WRITE_HIGH)));
                else
                    queue_command(8'($urandom_range(OP_SKIP_FIVE, 8'hFF)));
            end
        endcase
        // bytes after the end should be swallowed without a transaction
        repeat (12)
            bytes_to_send.push_back(8'($urandom_range(0, 255)));

        wait_idle();
        repeat (12) @(posedge clk);
        if (mismatch_count == 0 && events_due.size() == 0)
            $display("vgm_command_decoder: match");
        else
            $display("vgm_command_decoder: mismatch");
        $finish;
    end

endmodule

>>> files.f
hdl/vgmcd_pkg.sv
hdl/vgm_command_decoder.sv
tb/vgm_command_decoder_tb.sv
